// ===== rtl/spq_pkg.sv =====
// spq_pkg: constants, status codes and cell control types for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 5;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell in the accepting cycle
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_if.sv =====
// spq_if: valid/ready channel interfaces for the queue's operation beats and result beats
`timescale 1ns / 1ps

interface spq_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic signed [spq_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface spq_out_if;
  logic                              valid;
  logic                              ready;
  logic [spq_pkg::STAT_W-1:0]        status;
  logic signed [spq_pkg::VAL_W-1:0]  removed_value;
  logic                              now_empty;
  logic [spq_pkg::ECNT_W-1:0]        entry_count;

  modport source (output valid, output status, output removed_value, output now_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value, input now_empty,
                  input entry_count, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted shift array, compares against the new value and shifts
`timescale 1ns / 1ps

module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_ctrl_t              ctrl,
  input  logic                             occupied,
  input  logic                             left_take,
  input  logic signed [spq_pkg::VAL_W-1:0] left_val,
  input  logic signed [spq_pkg::VAL_W-1:0] right_val,
  output logic                             take,
  output logic signed [spq_pkg::VAL_W-1:0] val
);

  logic signed [spq_pkg::VAL_W-1:0] val_r;
  logic signed [spq_pkg::VAL_W-1:0] val_nxt;

  // a held entry greater than the new value moves right; a free slot also takes
  assign take = !occupied || (val_r > ctrl.value);
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins && take) begin
      val_nxt = left_take ? left_val : ctrl.value;
    end else if (ctrl.rem) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// sorted_priority_queue: bounded min-priority queue built from a chain of sorting cells
//
//   channel   dir  beat contents
//   in_chan   in   operation, value
//   out_chan  out  status, removed_value, now_empty, entry_count
//
// one beat per cycle while the output is not stalled: every cell compares and shifts in the
// cycle a beat is accepted, and the result sits in an output register the next cycle.
// a new beat is taken whenever the output register is empty or being drained.
// rst_n (synchronous, active low) clears the count and the output valid; cell contents
// stay as they are and are never read before being written.
// a stalled output holds its result and blocks further input beats.
`timescale 1ns / 1ps

module sorted_priority_queue (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_chan,
  spq_out_if.source out_chan
);

  localparam int N = spq_pkg::CAPACITY;

  logic [spq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      out_valid_r;
  logic [spq_pkg::STAT_W-1:0]       status_r;
  logic signed [spq_pkg::VAL_W-1:0] removed_r;
  logic                             empty_r;
  logic [spq_pkg::ECNT_W-1:0]       ecnt_r;

  logic                      accept;
  logic                      is_full, is_empty;
  spq_pkg::status_t          status_nxt;
  spq_pkg::cell_ctrl_t       ctrl;

  logic                             take [N];
  logic signed [spq_pkg::VAL_W-1:0] cval [N];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_full       = (count_r == spq_pkg::CNT_W'(N));
  assign is_empty      = (count_r == '0);

  always_comb begin
    status_nxt = spq_pkg::ST_DONE;
    count_nxt  = count_r;
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.value = in_chan.value;
    if (in_chan.operation == spq_pkg::OP_INSERT) begin
      if (is_full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        ctrl.ins  = accept;
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        ctrl.rem  = accept;
        count_nxt = count_r - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                             occ;
    logic                             lt;
    logic signed [spq_pkg::VAL_W-1:0] lv;
    logic signed [spq_pkg::VAL_W-1:0] rv;

    assign occ = (count_r > spq_pkg::CNT_W'(i));
    if (i == 0) begin : g_head
      assign lt = 1'b0;
      assign lv = '0;
    end else begin : g_mid
      assign lt = take[i-1];
      assign lv = cval[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign rv = '0;
    end else begin : g_body
      assign rv = cval[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .left_take (lt),
      .left_val  (lv),
      .right_val (rv),
      .take      (take[i]),
      .val       (cval[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= (ctrl.rem) ? cval[0] : '0;
      empty_r   <= (count_nxt == '0);
      ecnt_r    <= spq_pkg::ECNT_W'(count_nxt);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.removed_value = removed_r;
  assign out_chan.now_empty     = empty_r;
  assign out_chan.entry_count   = ecnt_r;

endmodule

// ===== verif/tb.sv =====
// tb: testbench for sorted_priority_queue, directed table then random beats checked by a predictor
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES = 40;
  localparam int RANDOM_BEATS = 900;
  localparam int CALM_FROM = 760;

  typedef struct packed {
    spq_pkg::status_t                 status;
    logic signed [spq_pkg::VAL_W-1:0] removed_value;
    logic                             now_empty;
    logic [spq_pkg::ECNT_W-1:0]       entry_count;
  } outcome_t;

  typedef struct packed {
    spq_pkg::op_t                     op;
    logic signed [spq_pkg::VAL_W-1:0] value;
    bit                               typed;
    outcome_t                         want;
  } stim_row_t;

  typedef enum int {MIX, FILL_UP, DRAIN} op_mix_t;

  // typed rows hold expectations that can be read off at a glance, the rest use the predictor
  localparam stim_row_t OPENING [20] = '{
    '{spq_pkg::OP_REMOVE, 32'h00000000, 1'b1, '{spq_pkg::ST_EMPTY, 32'h00000000, 1'b1, 5'd0}},
    '{spq_pkg::OP_INSERT, 32'h7fffffff, 1'b1, '{spq_pkg::ST_DONE, 32'h00000000, 1'b0, 5'd1}},
    '{spq_pkg::OP_INSERT, 32'h80000000, 1'b1, '{spq_pkg::ST_DONE, 32'h00000000, 1'b0, 5'd2}},
    '{spq_pkg::OP_INSERT, 32'h00000000, 1'b1, '{spq_pkg::ST_DONE, 32'h00000000, 1'b0, 5'd3}},
    '{spq_pkg::OP_INSERT, 32'h00000000, 1'b1, '{spq_pkg::ST_DONE, 32'h00000000, 1'b0, 5'd4}},
    '{spq_pkg::OP_INSERT, 32'hffffffff, 1'b1, '{spq_pkg::ST_DONE, 32'h00000000, 1'b0, 5'd5}},
    '{spq_pkg::OP_INSERT, 32'h55555555, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'haaaaaaaa, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'h00000001, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'hfffffffe, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'h7ffffffe, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'h80000001, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'h12345678, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'hedcba987, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'h0000ffff, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'hffff0000, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'h3c3c3c3c, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'h40000000, 1'b1, '{spq_pkg::ST_FULL, 32'h00000000, 1'b0, 5'd16}},
    '{spq_pkg::OP_REMOVE, 32'hdeadbeef, 1'b1, '{spq_pkg::ST_DONE, 32'h80000000, 1'b0, 5'd15}},
    '{spq_pkg::OP_REMOVE, 32'h00000000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_chan ();
  spq_out_if out_chan ();

  sorted_priority_queue dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always #5 clk = ~clk;

  logic signed [spq_pkg::VAL_W-1:0] held_vals [$];
  outcome_t                         awaited_results [$];
  int                               errors = 0;
  bit                               calm = 1'b0;
  bit                               hold_pending = 1'b0;

  // ascending store, a new value goes after the equal ones already held
  function automatic outcome_t queue_step(spq_pkg::op_t op,
                                          logic signed [spq_pkg::VAL_W-1:0] v);
    outcome_t r;
    int pos;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_vals.size() >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_vals.size() && held_vals[pos] <= v) pos++;
        held_vals.insert(pos, v);
      end
    end else if (held_vals.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.removed_value = held_vals.pop_front();
    end
    r.now_empty = (held_vals.size() == 0);
    r.entry_count = spq_pkg::ECNT_W'(held_vals.size());
    return r;
  endfunction

  // offer one beat, sometimes after a random gap until calm, and record the expectation once it is taken
  task automatic offer_beat(input spq_pkg::op_t op, input logic signed [spq_pkg::VAL_W-1:0] v,
                            input bit typed, input outcome_t want);
    outcome_t pred;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.value <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pred = queue_step(op, v);
    awaited_results.push_back(typed ? want : pred);
  endtask

  // result side: random stall bursts, plus long holds on request so the input backs up
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d value %h count %0d",
                 $time, out_chan.status, out_chan.removed_value, out_chan.entry_count);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_chan.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_chan.status);
          errors++;
        end
        if (out_chan.removed_value !== want.removed_value) begin
          $display("%0t: removed_value expected %h actual %h",
                   $time, want.removed_value, out_chan.removed_value);
          errors++;
        end
        if (out_chan.now_empty !== want.now_empty) begin
          $display("%0t: now_empty expected %0d actual %0d",
                   $time, want.now_empty, out_chan.now_empty);
          errors++;
        end
        if (out_chan.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, out_chan.entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int n;
    int phase_left;
    int kind;
    int guard;
    op_mix_t mix;
    spq_pkg::op_t op;
    logic signed [spq_pkg::VAL_W-1:0] v;
    in_chan.valid <= 1'b0;
    in_chan.operation <= spq_pkg::OP_INSERT;
    in_chan.value <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING[i]) offer_beat(OPENING[i].op, OPENING[i].value, OPENING[i].typed,
                                    OPENING[i].want);

    phase_left = 0;
    mix = MIX;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 20 || n == 420) begin
        hold_pending = 1'b1;
        mix = FILL_UP;
        phase_left = 50;
      end
      if (n == CALM_FROM) calm = 1'b1;
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: mix = MIX;
          1: mix = FILL_UP;
          default: mix = DRAIN;
        endcase
      end
      phase_left--;
      case (mix)
        FILL_UP: op = ($urandom_range(0, 9) < 8) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        DRAIN:   op = ($urandom_range(0, 9) < 8) ? spq_pkg::OP_REMOVE : spq_pkg::OP_INSERT;
        default: op = $urandom_range(0, 1) ? spq_pkg::OP_REMOVE : spq_pkg::OP_INSERT;
      endcase
      kind = $urandom_range(0, 9);
      // narrow ranges give plenty of ties, extremes exercise the signed compare
      if (kind < 6) begin
        v = $urandom;
      end else if (kind < 8) begin
        v = $signed($urandom_range(0, 6)) - 3;
      end else begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = 32'h00000000;
          default: v = 32'hffffffff;
        endcase
      end
      offer_beat(op, v, 1'b0, '0);
    end
    in_chan.valid <= 1'b0;

    guard = 0;
    while (awaited_results.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
